[rtl/bcm_pkg.sv]
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared types and constants for the blob centroid merge block: field widths,
// command and status codes, queue entry layout and back-end states.
// ----------------------------------------------------------------------------
package bcm_pkg;

    localparam int ACTION_BITS = 2;
    localparam int FIELD_BITS  = 16;
    localparam int CAP_BITS    = 5;
    localparam int STATUS_BITS = 3;
    localparam int INDEX_BITS  = 4;
    localparam int RAD_BITS    = 8;
    localparam int RAD16_BITS  = RAD_BITS + 4;
    localparam int SQ_BITS     = 2 * RAD16_BITS;
    localparam int CFG_IDX_BITS = 1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ACTION_BITS-1:0] ACT_START = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_BLOB  = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_READ  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_RED_RADIUS   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GREEN_RADIUS = 1'd1;

    localparam logic [RAD_BITS-1:0] RED_RADIUS_RESET   = 8'd5;
    localparam logic [RAD_BITS-1:0] GREEN_RADIUS_RESET = 8'd15;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_BLOB,
        CMD_READ
    } cmd_kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_STARTED  = 3'd0,
        ST_MERGED   = 3'd1,
        ST_APPENDED = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_ENTRY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_DECIDE,
        BK_RD_ISSUE,
        BK_RD_EMIT
    } back_state_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic                  blob_is_red;
        logic [FIELD_BITS-1:0] blob_x;
        logic [FIELD_BITS-1:0] blob_y;
        logic [CAP_BITS-1:0]   red_capacity;
        logic [CAP_BITS-1:0]   green_capacity;
    } cmd_t;

    typedef struct packed {
        logic [RAD_BITS-1:0] red_radius;
        logic [RAD_BITS-1:0] green_radius;
    } radius_cfg_t;

endpackage

[rtl/bcm_in_if.sv]
// ----------------------------------------------------------------------------
// bcm_in_if
// Input channel: one beat is a start, blob or readout command.
// ----------------------------------------------------------------------------
interface bcm_in_if;
    import bcm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ACTION_BITS-1:0] action;
    logic                   blob_is_red;
    logic [FIELD_BITS-1:0]  blob_x;
    logic [FIELD_BITS-1:0]  blob_y;
    logic [CAP_BITS-1:0]    red_capacity;
    logic [CAP_BITS-1:0]    green_capacity;

    modport source (
        output valid, action, blob_is_red, blob_x, blob_y, red_capacity, green_capacity,
        input  ready
    );

    modport sink (
        input  valid, action, blob_is_red, blob_x, blob_y, red_capacity, green_capacity,
        output ready
    );
endinterface

[rtl/bcm_out_if.sv]
// ----------------------------------------------------------------------------
// bcm_out_if
// Result channel: status beats and readout entries.
// ----------------------------------------------------------------------------
interface bcm_out_if;
    import bcm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic                   entry_is_red;
    logic [INDEX_BITS-1:0]  entry_index;
    logic                   entry_valid;
    logic [FIELD_BITS-1:0]  entry_x;
    logic [FIELD_BITS-1:0]  entry_y;
    logic                   last;

    modport source (
        output valid, status, entry_is_red, entry_index, entry_valid, entry_x, entry_y,
        output last,
        input  ready
    );

    modport sink (
        input  valid, status, entry_is_red, entry_index, entry_valid, entry_x, entry_y,
        input  last,
        output ready
    );
endinterface

[rtl/bcm_cfg_if.sv]
// ----------------------------------------------------------------------------
// bcm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bcm_cfg_if;
    import bcm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [RAD_BITS-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/blob_centroid_merge.sv]
// Start: result registered when the back end is idle and the result register is free.
// Blob: from acceptance to result valid: a latch step, one compare per slot of the color
//   through the marker memory read port, a drain of the compare pipeline, then a decision.
// Readout: each entry is read from the marker memory, then emitted; 2*MAX_MARKERS entries.
//   One command at a time in the back; a two-entry queue in front.
// Reset (async, rst_n low): tables empty, fill counts and limits zero, radii 5 and 15.
// ----------------------------------------------------------------------------
// blob_centroid_merge
// Merges red and green blob centroids into two marker tables with
// configurable merge radii, and lists both tables on request.
// ----------------------------------------------------------------------------
module blob_centroid_merge #(
    parameter int MAX_MARKERS = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    bcm_in_if.sink    in_ch,
    bcm_out_if.source out_ch,
    bcm_cfg_if.sink   cfg_ch
);
    import bcm_pkg::*;

    radius_cfg_t radius_reg;
    logic        push;
    cmd_t        push_data;
    logic        q_full;
    logic        q_not_empty;
    logic        q_pop;
    cmd_t        q_head;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg.red_radius   <= RED_RADIUS_RESET;
            radius_reg.green_radius <= GREEN_RADIUS_RESET;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_RED_RADIUS:   radius_reg.red_radius   <= cfg_ch.data;
                REG_GREEN_RADIUS: radius_reg.green_radius <= cfg_ch.data;
                default:          radius_reg <= radius_reg;
            endcase
        end
    end

    bcm_front u_front (
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    bcm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    bcm_back #(
        .MAX_MARKERS (MAX_MARKERS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_not_empty),
        .cmd        (q_head),
        .cmd_pop    (q_pop),
        .radius_cfg (radius_reg),
        .out_ch     (out_ch)
    );

endmodule

[rtl/bcm_front.sv]
// ----------------------------------------------------------------------------
// bcm_front
// Accepts input beats, decodes the action code and pushes a command into
// the queue. Undefined action codes are accepted and dropped.
// ----------------------------------------------------------------------------
module bcm_front (
    bcm_in_if.sink         in_ch,
    input  logic           q_full,
    output logic           push,
    output bcm_pkg::cmd_t  push_data
);
    import bcm_pkg::*;

    logic      known;
    cmd_kind_t kind;

    always_comb
    begin
        known = 1'b1;
        kind  = CMD_START;
        unique case (in_ch.action)
            ACT_START: kind = CMD_START;
            ACT_BLOB:  kind = CMD_BLOB;
            ACT_READ:  kind = CMD_READ;
            default:   known = 1'b0;
        endcase
    end

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full && known;

    assign push_data.kind           = kind;
    assign push_data.blob_is_red    = in_ch.blob_is_red;
    assign push_data.blob_x         = in_ch.blob_x;
    assign push_data.blob_y         = in_ch.blob_y;
    assign push_data.red_capacity   = in_ch.red_capacity;
    assign push_data.green_capacity = in_ch.green_capacity;

endmodule

[rtl/bcm_queue.sv]
// ----------------------------------------------------------------------------
// bcm_queue
// Short command FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module bcm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bcm_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output bcm_pkg::cmd_t head
);
    import bcm_pkg::*;

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/bcm_back.sv]
// ----------------------------------------------------------------------------
// bcm_back
// Executes commands: frame start, blob merge scan over the marker memory
// and table readout. Drives the result register.
// ----------------------------------------------------------------------------
module bcm_back #(
    parameter int MAX_MARKERS = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  bcm_pkg::cmd_t        cmd,
    output logic                 cmd_pop,
    input  bcm_pkg::radius_cfg_t radius_cfg,
    bcm_out_if.source            out_ch
);
    import bcm_pkg::*;

    localparam int SLOTS = 2 * MAX_MARKERS;
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int FW    = $clog2(MAX_MARKERS + 1);
    localparam int DW    = (COORD_BITS > RAD16_BITS) ? COORD_BITS : RAD16_BITS;

    // marker memory: red slot i at i, green slot i at MAX_MARKERS + i
    logic [COORD_BITS-1:0] mem_x [SLOTS];
    logic [COORD_BITS-1:0] mem_y [SLOTS];
    logic [COORD_BITS-1:0] rd_x_reg;
    logic [COORD_BITS-1:0] rd_y_reg;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [COORD_BITS-1:0] wr_x;
    logic [COORD_BITS-1:0] wr_y;

    logic [SLOTS-1:0]      valid_reg;
    logic [FW-1:0]         red_fill_reg;
    logic [FW-1:0]         green_fill_reg;
    logic [FW-1:0]         red_limit_reg;
    logic [FW-1:0]         green_limit_reg;

    back_state_t           state_reg;
    back_state_t           state_next;
    logic [CW-1:0]         cnt_reg;

    // current blob
    logic                  blob_red_reg;
    logic [COORD_BITS-1:0] bx_reg;
    logic [COORD_BITS-1:0] by_reg;
    logic [RAD16_BITS-1:0] r16_reg;
    logic [SQ_BITS-1:0]    rsq_reg;
    logic                  matched_reg;

    // compare pipeline
    logic                  s1_valid_reg;
    logic [AW-1:0]         s1_slot_reg;
    logic                  s2_valid_reg;
    logic [AW-1:0]         s2_slot_reg;
    logic                  s2_near_reg;
    logic [RAD16_BITS-1:0] s2_dx_reg;
    logic [RAD16_BITS-1:0] s2_dy_reg;
    logic [COORD_BITS-1:0] s2_mx_reg;
    logic [COORD_BITS-1:0] s2_my_reg;
    logic                  s3_valid_reg;
    logic [AW-1:0]         s3_slot_reg;
    logic                  s3_near_reg;
    logic [SQ_BITS-1:0]    s3_sqx_reg;
    logic [SQ_BITS-1:0]    s3_sqy_reg;
    logic [COORD_BITS-1:0] s3_mx_reg;
    logic [COORD_BITS-1:0] s3_my_reg;

    // result register
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic                  out_is_red_reg;
    logic [INDEX_BITS-1:0] out_index_reg;
    logic                  out_entry_valid_reg;
    logic [FIELD_BITS-1:0] out_x_reg;
    logic [FIELD_BITS-1:0] out_y_reg;
    logic                  out_last_reg;

    // control strobes
    logic                  out_free;
    logic                  out_load;
    status_t               res_status;
    logic                  res_is_red;
    logic [INDEX_BITS-1:0] res_index;
    logic                  res_valid;
    logic [FIELD_BITS-1:0] res_x;
    logic [FIELD_BITS-1:0] res_y;
    logic                  res_last;
    logic                  blob_latch;
    logic                  scan_issue;
    logic                  cnt_clr;
    logic                  cnt_inc;
    logic                  frame_start;
    logic                  app_en;
    logic                  clear_all;

    logic [AW-1:0]         scan_addr;
    logic [FW-1:0]         fill_sel;
    logic [FW-1:0]         limit_sel;
    logic                  can_append;
    logic [AW-1:0]         app_addr;
    logic                  rd_is_red;
    logic [CW-1:0]         rd_idx;
    logic                  rd_last;
    logic                  commit;
    logic [COORD_BITS-1:0] s1_dx;
    logic [COORD_BITS-1:0] s1_dy;
    logic [RAD_BITS-1:0]   radius_sel;

    function automatic logic [FW-1:0] sat_cap(input logic [CAP_BITS-1:0] cap);
        logic [CAP_BITS:0] wide;
        wide = {1'b0, cap};
        if (wide > (CAP_BITS + 1)'(MAX_MARKERS))
        begin
            return FW'(MAX_MARKERS);
        end
        return FW'(cap);
    endfunction

    assign out_free   = !out_valid_reg || out_ch.ready;
    assign scan_addr  = blob_red_reg ? AW'(cnt_reg) : AW'(cnt_reg) + AW'(MAX_MARKERS);
    assign fill_sel   = blob_red_reg ? red_fill_reg : green_fill_reg;
    assign limit_sel  = blob_red_reg ? red_limit_reg : green_limit_reg;
    assign can_append = (fill_sel < limit_sel) && (fill_sel < FW'(MAX_MARKERS));
    assign app_addr   = blob_red_reg ? AW'(fill_sel) : AW'(fill_sel) + AW'(MAX_MARKERS);
    assign rd_is_red  = cnt_reg < CW'(MAX_MARKERS);
    assign rd_idx     = rd_is_red ? cnt_reg : cnt_reg - CW'(MAX_MARKERS);
    assign rd_last    = cnt_reg == CW'(SLOTS - 1);
    assign radius_sel = cmd.blob_is_red ? radius_cfg.red_radius : radius_cfg.green_radius;

    // squared distance within squared radius
    assign commit = s3_valid_reg && s3_near_reg &&
                    ((SQ_BITS + 1)'(s3_sqx_reg) + (SQ_BITS + 1)'(s3_sqy_reg)
                     <= (SQ_BITS + 1)'(rsq_reg));

    always_comb
    begin
        state_next  = state_reg;
        cmd_pop     = 1'b0;
        blob_latch  = 1'b0;
        scan_issue  = 1'b0;
        cnt_clr     = 1'b0;
        cnt_inc     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = scan_addr;
        out_load    = 1'b0;
        frame_start = 1'b0;
        app_en      = 1'b0;
        clear_all   = 1'b0;
        res_status  = ST_STARTED;
        res_is_red  = 1'b0;
        res_index   = '0;
        res_valid   = 1'b0;
        res_x       = '0;
        res_y       = '0;
        res_last    = 1'b1;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_START:
                        begin
                            if (out_free)
                            begin
                                cmd_pop     = 1'b1;
                                frame_start = 1'b1;
                                out_load    = 1'b1;
                            end
                        end
                        CMD_BLOB:
                        begin
                            cmd_pop    = 1'b1;
                            blob_latch = 1'b1;
                            cnt_clr    = 1'b1;
                            state_next = BK_SCAN;
                        end
                        CMD_READ:
                        begin
                            cmd_pop    = 1'b1;
                            cnt_clr    = 1'b1;
                            state_next = BK_RD_ISSUE;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                rd_en      = 1'b1;
                scan_issue = 1'b1;
                cnt_inc    = 1'b1;
                if (cnt_reg == CW'(MAX_MARKERS - 1))
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg)
                begin
                    state_next = BK_DECIDE;
                end
            end
            BK_DECIDE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                    priority if (matched_reg)
                    begin
                        res_status = ST_MERGED;
                    end
                    else if (can_append)
                    begin
                        app_en     = 1'b1;
                        res_status = ST_APPENDED;
                    end
                    else
                    begin
                        clear_all  = 1'b1;
                        res_status = ST_OVERFLOW;
                    end
                end
            end
            BK_RD_ISSUE:
            begin
                rd_en      = 1'b1;
                rd_addr    = cnt_reg[AW-1:0];
                state_next = BK_RD_EMIT;
            end
            BK_RD_EMIT:
            begin
                res_status = ST_ENTRY;
                res_is_red = rd_is_red;
                res_index  = INDEX_BITS'(rd_idx);
                res_valid  = valid_reg[cnt_reg[AW-1:0]];
                res_x      = res_valid ? FIELD_BITS'(rd_x_reg) : '0;
                res_y      = res_valid ? FIELD_BITS'(rd_y_reg) : '0;
                res_last   = rd_last;
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (rd_last)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        cnt_inc    = 1'b1;
                        state_next = BK_RD_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // single write port: merge commits during the scan, append at decision
    always_comb
    begin
        wr_en   = commit || app_en;
        wr_addr = app_en ? app_addr : s3_slot_reg;
        wr_x    = app_en ? bx_reg
                         : COORD_BITS'(({1'b0, s3_mx_reg} + {1'b0, bx_reg}) >> 1);
        wr_y    = app_en ? by_reg
                         : COORD_BITS'(({1'b0, s3_my_reg} + {1'b0, by_reg}) >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
        end
    end

    assign s1_dx = (rd_x_reg > bx_reg) ? rd_x_reg - bx_reg : bx_reg - rd_x_reg;
    assign s1_dy = (rd_y_reg > by_reg) ? rd_y_reg - by_reg : by_reg - rd_y_reg;

    // compare pipeline datapath
    always_ff @(posedge clk)
    begin
        if (blob_latch)
        begin
            blob_red_reg <= cmd.blob_is_red;
            bx_reg       <= COORD_BITS'(cmd.blob_x);
            by_reg       <= COORD_BITS'(cmd.blob_y);
            r16_reg      <= {radius_sel, 4'b0000};
        end
        rsq_reg <= r16_reg * r16_reg;

        s1_slot_reg <= rd_addr;

        s2_slot_reg <= s1_slot_reg;
        s2_near_reg <= valid_reg[s1_slot_reg] &&
                       (DW'(s1_dx) <= DW'(r16_reg)) && (DW'(s1_dy) <= DW'(r16_reg));
        s2_dx_reg   <= RAD16_BITS'(s1_dx);
        s2_dy_reg   <= RAD16_BITS'(s1_dy);
        s2_mx_reg   <= rd_x_reg;
        s2_my_reg   <= rd_y_reg;

        s3_slot_reg <= s2_slot_reg;
        s3_near_reg <= s2_near_reg;
        s3_sqx_reg  <= s2_dx_reg * s2_dx_reg;
        s3_sqy_reg  <= s2_dy_reg * s2_dy_reg;
        s3_mx_reg   <= s2_mx_reg;
        s3_my_reg   <= s2_my_reg;

        if (out_load)
        begin
            out_status_reg      <= res_status;
            out_is_red_reg      <= res_is_red;
            out_index_reg       <= res_index;
            out_entry_valid_reg <= res_valid;
            out_x_reg           <= res_x;
            out_y_reg           <= res_y;
            out_last_reg        <= res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            cnt_reg         <= '0;
            valid_reg       <= '0;
            red_fill_reg    <= '0;
            green_fill_reg  <= '0;
            red_limit_reg   <= '0;
            green_limit_reg <= '0;
            matched_reg     <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            s1_valid_reg <= scan_issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;

            if (blob_latch)
            begin
                matched_reg <= 1'b0;
            end
            else if (commit)
            begin
                matched_reg <= 1'b1;
            end

            if (frame_start || clear_all)
            begin
                valid_reg <= '0;
            end
            else if (app_en)
            begin
                valid_reg[app_addr] <= 1'b1;
            end

            // overflow keeps the fill counts
            if (frame_start)
            begin
                red_fill_reg    <= '0;
                green_fill_reg  <= '0;
                red_limit_reg   <= sat_cap(cmd.red_capacity);
                green_limit_reg <= sat_cap(cmd.green_capacity);
            end
            else if (app_en)
            begin
                if (blob_red_reg)
                begin
                    red_fill_reg <= red_fill_reg + 1'b1;
                end
                else
                begin
                    green_fill_reg <= green_fill_reg + 1'b1;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.entry_is_red = out_is_red_reg;
    assign out_ch.entry_index  = out_index_reg;
    assign out_ch.entry_valid  = out_entry_valid_reg;
    assign out_ch.entry_x      = out_x_reg;
    assign out_ch.entry_y      = out_y_reg;
    assign out_ch.last         = out_last_reg;

endmodule
